/* src/i2cras_pkg.sv */
// Shared types, codes and device table of the I2C register access sequencer.
// Depends on nothing; every other file of the block refers to it by scoped names.
package i2cras_pkg;

  // Retry budget, burst limit and device table size
  localparam int unsigned MaxAttempts = 8;
  localparam int unsigned AttemptW    = 4;
  localparam int unsigned MaxBurst    = 256;
  localparam int unsigned CountW      = 9;
  localparam int unsigned DeviceCount = 15;
  localparam int unsigned TableLen    = 15;
  localparam int unsigned DevLimit    = (DeviceCount < TableLen) ? DeviceCount : TableLen;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_DEV    = 4'd1;
  localparam logic [3:0] PH_REG    = 4'd2;
  localparam logic [3:0] PH_DEVR   = 4'd3;
  localparam logic [3:0] PH_RSTOP1 = 4'd4;
  localparam logic [3:0] PH_RSTOP2 = 4'd5;
  localparam logic [3:0] PH_WDATA  = 4'd6;
  localparam logic [3:0] PH_WSTOP1 = 4'd7;
  localparam logic [3:0] PH_WSTOP2 = 4'd8;
  localparam logic [3:0] PH_BREAD  = 4'd9;
  localparam logic [3:0] PH_BLAST  = 4'd10;
  localparam logic [3:0] PH_ABORT  = 4'd11;

  // Input item selector
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_BURST = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_DONE  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // Controller control register values
  localparam logic [7:0] CTRL_START     = 8'hC2;
  localparam logic [7:0] CTRL_SEND      = 8'hC0;
  localparam logic [7:0] CTRL_SEND_DATA = 8'hC1;
  localparam logic [7:0] CTRL_ABORT     = 8'hC5;
  localparam logic [7:0] CTRL_READ_ACK  = 8'hF0;
  localparam logic [7:0] CTRL_READ_LAST = 8'hE1;
  localparam logic [7:0] CTRL_READ_NACK = 8'hE0;
  localparam logic [7:0] FAIL_BYTE      = 8'hFF;

  typedef struct packed {
    logic [1:0]        func;
    logic [3:0]        device_index;
    logic [7:0]        register_address;
    logic [7:0]        write_value;
    logic [CountW-1:0] byte_count;
    logic              ack_seen;
    logic [7:0]        received_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] bus_select;
    logic [7:0] control_byte;
    logic       load_data;
    logic [7:0] data_byte;
    logic [7:0] byte_position;
    logic       success;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [3:0]          phase;
    logic [1:0]          request_mode;
    logic [AttemptW-1:0] attempts_left;
    logic [1:0]          bus_number;
    logic [7:0]          device_address;
    logic [7:0]          target_register;
    logic [7:0]          value_to_write;
    logic [CountW-1:0]   bytes_left;
    logic [7:0]          byte_index;
  } state_t;

  function automatic logic [1:0] dev_bus(input logic [3:0] idx);
    logic [1:0] bus;
    unique case (idx) inside
      [4'd0:4'd2]:  bus = 2'd0;
      [4'd3:4'd8]:  bus = 2'd1;
      [4'd9:4'd14]: bus = 2'd2;
      default:      bus = 2'd0;
    endcase
    return bus;
  endfunction

  function automatic logic [7:0] lookup_address(input logic [3:0] idx);
    logic [7:0] addr;
    unique case (idx)
      4'd0:    addr = 8'h4A;
      4'd1:    addr = 8'h7A;
      4'd2:    addr = 8'h78;
      4'd3:    addr = 8'h4A;
      4'd4:    addr = 8'h78;
      4'd5:    addr = 8'h2C;
      4'd6:    addr = 8'h2E;
      4'd7:    addr = 8'h40;
      4'd8:    addr = 8'h44;
      4'd9:    addr = 8'hD6;
      4'd10:   addr = 8'hD0;
      4'd11:   addr = 8'hD2;
      4'd12:   addr = 8'hA4;
      4'd13:   addr = 8'h9A;
      4'd14:   addr = 8'hA0;
      default: addr = 8'h00;
    endcase
    return addr;
  endfunction

endpackage

/* src/i2c_register_access_sequencer.sv */
// Top level of the I2C register access sequencer: input stage, sequencer state,
// result buffer and stream ports. Depends on i2cras_pkg, i2cras_step, i2cras_outbuf.

// The block drives a byte-level I2C controller through register read, burst read
// and register write requests; every controller command it issues waits for a
// done report (func 3) on the same input stream. An input transfer lands in a
// one-entry input register, and the sequencer step resolves it, once its results fit,
// into zero, one or two results that go into a two-slot output buffer, so
// a new item is taken every cycle while the result side keeps up. The first result
// of an item reaches the output through the input register and the output buffer.
// The rate is set by the output side, which hands out one result per cycle while
// the receiver is ready: an item that makes two results (a burst byte plus the next
// command or the finish) waits in the input register until both fit behind the
// current output transfer, which takes longer while the receiver stalls.
// Requests while busy and done reports while idle make no result.
module i2c_register_access_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [3:0] device_index, [11:4] register_address, [19:12] write_value,
  // [28:20] byte_count, [29] ack_seen, [37:30] received_byte, [39:38] zero
  input  logic [39:0] s_axis_tdata_i,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] bus_select, [9:2] control_byte, [10] load_data, [18:11] data_byte,
  // [26:19] byte_position, [27] success, [31:28] zero
  output logic [31:0] m_axis_tdata_o,
  // [1:0] kind
  output logic [1:0]  m_axis_tuser_o,
  // last result caused by one input item
  output logic        m_axis_tlast_o
);

  logic                in_valid_q;
  i2cras_pkg::item_t   in_item_q;
  i2cras_pkg::item_t   in_item;
  i2cras_pkg::state_t  st_q, st_d;
  i2cras_pkg::result_t res0, res1, head;
  logic [1:0]          n_res;
  logic [1:0]          count;
  logic [2:0]          space;
  logic                pop;
  logic                process;
  logic                in_xfer;

  // unpack the slave-side transfer
  assign in_item.func             = s_axis_tuser_i;
  assign in_item.device_index     = s_axis_tdata_i[3:0];
  assign in_item.register_address = s_axis_tdata_i[11:4];
  assign in_item.write_value      = s_axis_tdata_i[19:12];
  assign in_item.byte_count       = s_axis_tdata_i[28:20];
  assign in_item.ack_seen         = s_axis_tdata_i[29];
  assign in_item.received_byte    = s_axis_tdata_i[37:30];

  i2cras_step u_step (
    .st_i   (st_q),
    .item_i (in_item_q),
    .st_o   (st_d),
    .res0_o (res0),
    .res1_o (res1),
    .n_o    (n_res)
  );

  // resolve the held item only when all its results fit behind this cycle's pop
  assign pop     = m_axis_tvalid_o && m_axis_tready_i;
  assign space   = 3'd2 - {1'b0, count} + {2'b00, pop};
  assign process = in_valid_q && ({1'b0, n_res} <= space);

  // take a new transfer whenever the input register is empty or empties this cycle
  assign s_axis_tready_o = !in_valid_q || process;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (process) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q <= in_item;
    end
  end

  // advance sequencer state once per resolved item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (process) begin
      st_q <= st_d;
    end
  end

  i2cras_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (process ? n_res : 2'd0),
    .res0_i  (res0),
    .res1_i  (res1),
    .pop_i   (pop),
    .count_o (count),
    .head_o  (head)
  );

  // drive the master-side transfer from the buffer head
  assign m_axis_tvalid_o = (count != 2'd0);
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = head.last;
  assign m_axis_tdata_o  = {4'h0, head.success, head.byte_position, head.data_byte,
                            head.load_data, head.control_byte, head.bus_select};

`ifndef SYNTHESIS
  a_buf_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= 2'd2)
    else $error("result buffer over capacity");

  a_pair_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && n_res == 2'd2) |=> (count != 2'd0))
    else $error("second result of an item lost");

  a_held_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !process) |=> (in_valid_q && $stable(in_item_q)))
    else $error("unresolved input item dropped or changed");

  a_attempts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.attempts_left <= i2cras_pkg::AttemptW'(i2cras_pkg::MaxAttempts))
    else $error("retry budget exceeded");
`endif

endmodule

/* src/i2cras_step.sv */
// Next-state and result logic of the sequencer for one registered item.
// Depends on i2cras_pkg for types, phase codes and the device table.
module i2cras_step (
  input  i2cras_pkg::state_t  st_i,
  input  i2cras_pkg::item_t   item_i,
  output i2cras_pkg::state_t  st_o,
  output i2cras_pkg::result_t res0_o,
  output i2cras_pkg::result_t res1_o,
  output logic [1:0]          n_o
);

  logic                           dev_ok;
  logic [i2cras_pkg::CountW-1:0]  cnt_clamped;
  logic [i2cras_pkg::CountW-1:0]  bl_dec;
  logic [1:0]                     new_bus;
  logic [7:0]                     new_addr;
  logic [7:0]                     fail_data;
  logic [i2cras_pkg::AttemptW-1:0] att_dec;

  function automatic i2cras_pkg::result_t mk(input logic [1:0] kind, input logic [1:0] bus,
                                             input logic [7:0] ctrl, input logic load,
                                             input logic [7:0] data, input logic [7:0] pos,
                                             input logic ok);
    i2cras_pkg::result_t r;
    r.kind          = kind;
    r.bus_select    = bus;
    r.control_byte  = ctrl;
    r.load_data     = load;
    r.data_byte     = data;
    r.byte_position = pos;
    r.success       = ok;
    r.last          = 1'b0;
    return r;
  endfunction

  assign dev_ok   = {1'b0, item_i.device_index} < 5'(i2cras_pkg::DevLimit);
  assign new_bus  = i2cras_pkg::dev_bus(item_i.device_index);
  assign new_addr = i2cras_pkg::lookup_address(item_i.device_index);
  assign bl_dec   = st_i.bytes_left - i2cras_pkg::CountW'(1);
  assign att_dec  = (st_i.attempts_left != '0) ?
                    st_i.attempts_left - i2cras_pkg::AttemptW'(1) : st_i.attempts_left;
  assign fail_data = (st_i.request_mode == i2cras_pkg::FUNC_READ) ?
                     i2cras_pkg::FAIL_BYTE : 8'h00;

  always_comb begin
    if (item_i.byte_count == '0) begin
      cnt_clamped = i2cras_pkg::CountW'(1);
    end else if (item_i.byte_count > i2cras_pkg::CountW'(i2cras_pkg::MaxBurst)) begin
      cnt_clamped = i2cras_pkg::CountW'(i2cras_pkg::MaxBurst);
    end else begin
      cnt_clamped = item_i.byte_count;
    end
  end

  always_comb begin
    st_o   = st_i;
    res0_o = '0;
    res1_o = '0;
    n_o    = 2'd0;
    if (item_i.func != i2cras_pkg::FUNC_DONE) begin
      // requests are dropped while a sequence runs
      if (st_i.phase == i2cras_pkg::PH_IDLE) begin
        st_o.request_mode = item_i.func;
        n_o = 2'd1;
        if (!dev_ok) begin
          st_o.bus_number = 2'd0;
          res0_o = mk(i2cras_pkg::KIND_FINISH, 2'd0, 8'h00, 1'b0,
                      (item_i.func == i2cras_pkg::FUNC_READ) ? i2cras_pkg::FAIL_BYTE : 8'h00,
                      8'h00, 1'b0);
        end else begin
          st_o.bus_number      = new_bus;
          st_o.device_address  = new_addr;
          st_o.target_register = item_i.register_address;
          st_o.value_to_write  = item_i.write_value;
          st_o.bytes_left      = cnt_clamped;
          st_o.byte_index      = 8'h00;
          st_o.attempts_left   = i2cras_pkg::AttemptW'(i2cras_pkg::MaxAttempts);
          st_o.phase           = i2cras_pkg::PH_DEV;
          res0_o = mk(i2cras_pkg::KIND_CMD, new_bus, i2cras_pkg::CTRL_START, 1'b1,
                      new_addr, 8'h00, 1'b0);
        end
      end
    end else begin
      unique case (st_i.phase)
        i2cras_pkg::PH_IDLE: begin
          n_o = 2'd0;
        end
        i2cras_pkg::PH_DEV: begin
          n_o = 2'd1;
          if (!item_i.ack_seen) begin
            st_o.phase = i2cras_pkg::PH_ABORT;
            res0_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_ABORT,
                        1'b0, 8'h00, 8'h00, 1'b0);
          end else begin
            st_o.phase = i2cras_pkg::PH_REG;
            res0_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_SEND,
                        1'b1, st_i.target_register, 8'h00, 1'b0);
          end
        end
        i2cras_pkg::PH_REG: begin
          n_o = 2'd1;
          if (!item_i.ack_seen) begin
            st_o.phase = i2cras_pkg::PH_ABORT;
            res0_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_ABORT,
                        1'b0, 8'h00, 8'h00, 1'b0);
          end else if (st_i.request_mode == i2cras_pkg::FUNC_WRITE) begin
            st_o.phase = i2cras_pkg::PH_WDATA;
            res0_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_SEND_DATA,
                        1'b1, st_i.value_to_write, 8'h00, 1'b0);
          end else begin
            st_o.phase = i2cras_pkg::PH_DEVR;
            res0_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_START,
                        1'b1, st_i.device_address | 8'h01, 8'h00, 1'b0);
          end
        end
        i2cras_pkg::PH_DEVR: begin
          n_o = 2'd1;
          if (!item_i.ack_seen) begin
            st_o.phase = i2cras_pkg::PH_ABORT;
            res0_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_ABORT,
                        1'b0, 8'h00, 8'h00, 1'b0);
          end else if (st_i.request_mode == i2cras_pkg::FUNC_BURST) begin
            if (st_i.bytes_left > i2cras_pkg::CountW'(1)) begin
              st_o.phase = i2cras_pkg::PH_BREAD;
              res0_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_READ_ACK,
                          1'b0, 8'h00, 8'h00, 1'b0);
            end else begin
              st_o.phase = i2cras_pkg::PH_BLAST;
              res0_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_READ_LAST,
                          1'b0, 8'h00, 8'h00, 1'b0);
            end
          end else begin
            st_o.phase = i2cras_pkg::PH_RSTOP1;
            res0_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_READ_NACK,
                        1'b0, 8'h00, 8'h00, 1'b0);
          end
        end
        i2cras_pkg::PH_RSTOP1: begin
          n_o = 2'd1;
          st_o.phase = i2cras_pkg::PH_RSTOP2;
          res0_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_ABORT,
                      1'b0, 8'h00, 8'h00, 1'b0);
        end
        i2cras_pkg::PH_RSTOP2: begin
          n_o = 2'd1;
          st_o.phase = i2cras_pkg::PH_IDLE;
          res0_o = mk(i2cras_pkg::KIND_FINISH, st_i.bus_number, 8'h00, 1'b0,
                      item_i.received_byte, 8'h00, 1'b1);
        end
        i2cras_pkg::PH_WDATA: begin
          n_o = 2'd1;
          st_o.phase = i2cras_pkg::PH_WSTOP1;
          res0_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_SEND,
                      1'b0, 8'h00, 8'h00, 1'b0);
        end
        i2cras_pkg::PH_WSTOP1: begin
          n_o = 2'd1;
          st_o.phase = i2cras_pkg::PH_WSTOP2;
          res0_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_ABORT,
                      1'b0, 8'h00, 8'h00, 1'b0);
        end
        i2cras_pkg::PH_WSTOP2: begin
          n_o = 2'd1;
          if (item_i.ack_seen) begin
            st_o.phase = i2cras_pkg::PH_IDLE;
            res0_o = mk(i2cras_pkg::KIND_FINISH, st_i.bus_number, 8'h00, 1'b0,
                        8'h00, 8'h00, 1'b1);
          end else begin
            st_o.phase = i2cras_pkg::PH_ABORT;
            res0_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_ABORT,
                        1'b0, 8'h00, 8'h00, 1'b0);
          end
        end
        i2cras_pkg::PH_BREAD: begin
          n_o = 2'd2;
          res0_o = mk(i2cras_pkg::KIND_BYTE, st_i.bus_number, 8'h00, 1'b0,
                      item_i.received_byte, st_i.byte_index, 1'b0);
          st_o.byte_index = st_i.byte_index + 8'd1;
          st_o.bytes_left = bl_dec;
          if (bl_dec > i2cras_pkg::CountW'(1)) begin
            st_o.phase = i2cras_pkg::PH_BREAD;
            res1_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_READ_ACK,
                        1'b0, 8'h00, 8'h00, 1'b0);
          end else begin
            st_o.phase = i2cras_pkg::PH_BLAST;
            res1_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_READ_LAST,
                        1'b0, 8'h00, 8'h00, 1'b0);
          end
        end
        i2cras_pkg::PH_BLAST: begin
          n_o = 2'd2;
          st_o.phase = i2cras_pkg::PH_IDLE;
          res0_o = mk(i2cras_pkg::KIND_BYTE, st_i.bus_number, 8'h00, 1'b0,
                      item_i.received_byte, st_i.byte_index, 1'b0);
          res1_o = mk(i2cras_pkg::KIND_FINISH, st_i.bus_number, 8'h00, 1'b0,
                      8'h00, 8'h00, 1'b1);
        end
        i2cras_pkg::PH_ABORT: begin
          n_o = 2'd1;
          st_o.attempts_left = att_dec;
          if (att_dec == '0) begin
            st_o.phase = i2cras_pkg::PH_IDLE;
            res0_o = mk(i2cras_pkg::KIND_FINISH, st_i.bus_number, 8'h00, 1'b0,
                        fail_data, 8'h00, 1'b0);
          end else begin
            st_o.byte_index = 8'h00;
            st_o.phase = i2cras_pkg::PH_DEV;
            res0_o = mk(i2cras_pkg::KIND_CMD, st_i.bus_number, i2cras_pkg::CTRL_START,
                        1'b1, st_i.device_address, 8'h00, 1'b0);
          end
        end
        default: begin
          // unused phase codes fall back to idle silently
          st_o.phase = i2cras_pkg::PH_IDLE;
          n_o = 2'd0;
        end
      endcase
    end
    if (n_o == 2'd1) begin
      res0_o.last = 1'b1;
    end
    if (n_o == 2'd2) begin
      res1_o.last = 1'b1;
    end
  end

endmodule

/* src/i2cras_outbuf.sv */
// Two-slot result buffer: takes up to two results per cycle, hands out one.
// Depends on i2cras_pkg for the result type.
module i2cras_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_i,
  input  i2cras_pkg::result_t res0_i,
  input  i2cras_pkg::result_t res1_i,
  input  logic                pop_i,
  output logic [1:0]          count_o,
  output i2cras_pkg::result_t head_o
);

  logic [1:0]          count_q, count_d;
  logic [1:0]          kept;
  i2cras_pkg::result_t slot0_q, slot0_d;
  i2cras_pkg::result_t slot1_q, slot1_d;

  // slot 0 is the head; a pop moves slot 1 forward
  assign kept = count_q - {1'b0, pop_i};

  always_comb begin
    slot0_d = pop_i ? slot1_q : slot0_q;
    slot1_d = slot1_q;
    case (kept)
      2'd0: begin
        slot0_d = res0_i;
        slot1_d = res1_i;
      end
      2'd1: begin
        slot1_d = res0_i;
      end
      default: begin
      end
    endcase
    count_d = kept + push_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign count_o = count_q;
  assign head_o  = slot0_q;

endmodule

/* tb/sv/i2cras_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the I2C register access sequencer: watches both stream channels,
// predicts every result from the accepted input transfers and compares it field by field.
// Depends on i2cras_pkg for the item codes, result kinds and controller control values.
module i2cras_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic [1:0]  m_tuser_i,
  input  logic        m_tlast_i,
  output int          fail_count_o,
  output int          pending_o
);

  // Device table, entry i at the i-th slice
  localparam logic [119:0] DEV_ADDRS = 120'hA0_9A_A4_D2_D0_D6_44_40_2E_2C_78_4A_78_7A_4A;
  localparam logic [29:0]  DEV_BUSES = 30'b10_10_10_10_10_10_01_01_01_01_01_01_00_00_00;

  // Predicted sequencer state
  logic [3:0]                      seq_phase;
  logic [1:0]                      seq_mode;
  logic [i2cras_pkg::AttemptW-1:0] tries_left;
  logic [1:0]                      cur_bus;
  logic [7:0]                      cur_device;
  logic [7:0]                      cur_reg;
  logic [7:0]                      cur_value;
  logic [i2cras_pkg::CountW-1:0]   burst_left;
  logic [7:0]                      burst_pos;

  i2cras_pkg::result_t awaited_results[$];
  int                  step_results;
  int                  mismatches;

  task automatic emit(input logic [1:0] kind, input logic [7:0] ctrl, input logic load,
                      input logic [7:0] data, input logic [7:0] pos, input logic ok);
    i2cras_pkg::result_t r;
    r.kind          = kind;
    r.bus_select    = cur_bus;
    r.control_byte  = ctrl;
    r.load_data     = load;
    r.data_byte     = data;
    r.byte_position = pos;
    r.success       = ok;
    r.last          = 1'b0;
    awaited_results.push_back(r);
    step_results++;
  endtask

  task automatic issue(input logic [7:0] ctrl, input logic load, input logic [7:0] data);
    emit(i2cras_pkg::KIND_CMD, ctrl, load, load ? data : 8'h00, 8'h00, 1'b0);
  endtask

  task automatic close_request(input logic ok, input logic [7:0] data);
    seq_phase = i2cras_pkg::PH_IDLE;
    emit(i2cras_pkg::KIND_FINISH, 8'h00, 1'b0, data, 8'h00, ok);
  endtask

  task automatic begin_attempt();
    seq_phase = i2cras_pkg::PH_DEV;
    issue(i2cras_pkg::CTRL_START, 1'b1, cur_device);
  endtask

  task automatic abort_attempt();
    seq_phase = i2cras_pkg::PH_ABORT;
    issue(i2cras_pkg::CTRL_ABORT, 1'b0, 8'h00);
  endtask

  task automatic next_burst_read();
    if (burst_left > 1) begin
      seq_phase = i2cras_pkg::PH_BREAD;
      issue(i2cras_pkg::CTRL_READ_ACK, 1'b0, 8'h00);
    end else begin
      seq_phase = i2cras_pkg::PH_BLAST;
      issue(i2cras_pkg::CTRL_READ_LAST, 1'b0, 8'h00);
    end
  endtask

  // One accepted input transfer: request or controller done report
  task automatic advance_sequencer(input logic [1:0] func, input logic [39:0] d);
    logic [3:0]                    dev;
    logic [i2cras_pkg::CountW-1:0] cnt;
    logic                          ack;
    logic [7:0]                    rx;
    logic [7:0]                    fail_data;
    i2cras_pkg::result_t           tail;
    dev  = d[3:0];
    cnt  = d[28:20];
    ack  = d[29];
    rx   = d[37:30];
    step_results = 0;
    fail_data = (seq_mode == i2cras_pkg::FUNC_READ) ? i2cras_pkg::FAIL_BYTE : 8'h00;
    if (func != i2cras_pkg::FUNC_DONE) begin
      if (seq_phase == i2cras_pkg::PH_IDLE) begin
        seq_mode = func;
        if (dev >= i2cras_pkg::DevLimit) begin
          cur_bus = 2'd0;
          close_request(1'b0, (func == i2cras_pkg::FUNC_READ) ? i2cras_pkg::FAIL_BYTE : 8'h00);
        end else begin
          if (cnt == 0) cnt = i2cras_pkg::CountW'(1);
          if (cnt > i2cras_pkg::MaxBurst) cnt = i2cras_pkg::CountW'(i2cras_pkg::MaxBurst);
          cur_bus      = DEV_BUSES[dev*2 +: 2];
          cur_device   = DEV_ADDRS[dev*8 +: 8];
          cur_reg      = d[11:4];
          cur_value    = d[19:12];
          burst_left   = cnt;
          burst_pos    = 8'h00;
          tries_left   = i2cras_pkg::AttemptW'(i2cras_pkg::MaxAttempts);
          begin_attempt();
        end
      end
    end else begin
      case (seq_phase)
        i2cras_pkg::PH_DEV: begin
          if (!ack) abort_attempt();
          else begin
            seq_phase = i2cras_pkg::PH_REG;
            issue(i2cras_pkg::CTRL_SEND, 1'b1, cur_reg);
          end
        end
        i2cras_pkg::PH_REG: begin
          if (!ack) abort_attempt();
          else if (seq_mode == i2cras_pkg::FUNC_WRITE) begin
            seq_phase = i2cras_pkg::PH_WDATA;
            issue(i2cras_pkg::CTRL_SEND_DATA, 1'b1, cur_value);
          end else begin
            seq_phase = i2cras_pkg::PH_DEVR;
            issue(i2cras_pkg::CTRL_START, 1'b1, cur_device | 8'h01);
          end
        end
        i2cras_pkg::PH_DEVR: begin
          if (!ack) abort_attempt();
          else if (seq_mode == i2cras_pkg::FUNC_BURST) next_burst_read();
          else begin
            seq_phase = i2cras_pkg::PH_RSTOP1;
            issue(i2cras_pkg::CTRL_READ_NACK, 1'b0, 8'h00);
          end
        end
        i2cras_pkg::PH_RSTOP1: begin
          seq_phase = i2cras_pkg::PH_RSTOP2;
          issue(i2cras_pkg::CTRL_ABORT, 1'b0, 8'h00);
        end
        i2cras_pkg::PH_RSTOP2: close_request(1'b1, rx);
        i2cras_pkg::PH_WDATA: begin
          seq_phase = i2cras_pkg::PH_WSTOP1;
          issue(i2cras_pkg::CTRL_SEND, 1'b0, 8'h00);
        end
        i2cras_pkg::PH_WSTOP1: begin
          seq_phase = i2cras_pkg::PH_WSTOP2;
          issue(i2cras_pkg::CTRL_ABORT, 1'b0, 8'h00);
        end
        i2cras_pkg::PH_WSTOP2: begin
          if (ack) close_request(1'b1, 8'h00);
          else abort_attempt();
        end
        i2cras_pkg::PH_BREAD: begin
          emit(i2cras_pkg::KIND_BYTE, 8'h00, 1'b0, rx, burst_pos, 1'b0);
          burst_pos  = burst_pos + 8'd1;
          burst_left = burst_left - i2cras_pkg::CountW'(1);
          next_burst_read();
        end
        i2cras_pkg::PH_BLAST: begin
          emit(i2cras_pkg::KIND_BYTE, 8'h00, 1'b0, rx, burst_pos, 1'b0);
          close_request(1'b1, 8'h00);
        end
        i2cras_pkg::PH_ABORT: begin
          if (tries_left > 0) tries_left = tries_left - i2cras_pkg::AttemptW'(1);
          if (tries_left == 0) close_request(1'b0, fail_data);
          else begin
            burst_pos = 8'h00;
            begin_attempt();
          end
        end
        default: seq_phase = i2cras_pkg::PH_IDLE;
      endcase
    end
    // Mark the final result of this step
    if (step_results > 0) begin
      tail = awaited_results.pop_back();
      tail.last = 1'b1;
      awaited_results.push_back(tail);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("result field %s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    i2cras_pkg::result_t want;
    if (!rst_ni) begin
      seq_phase    = i2cras_pkg::PH_IDLE;
      seq_mode     = i2cras_pkg::FUNC_READ;
      tries_left   = '0;
      cur_bus      = '0;
      cur_device   = '0;
      cur_reg      = '0;
      cur_value    = '0;
      burst_left   = '0;
      burst_pos    = '0;
      awaited_results.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) advance_sequencer(s_tuser_i, s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result with no prediction waiting: tuser %0h tdata %0h", m_tuser_i, m_tdata_i);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", 8'(want.kind), 8'(m_tuser_i));
          check_field("bus_select", 8'(want.bus_select), 8'(m_tdata_i[1:0]));
          check_field("control_byte", want.control_byte, m_tdata_i[9:2]);
          check_field("load_data", 8'(want.load_data), 8'(m_tdata_i[10]));
          check_field("data_byte", want.data_byte, m_tdata_i[18:11]);
          check_field("byte_position", want.byte_position, m_tdata_i[26:19]);
          check_field("success", 8'(want.success), 8'(m_tdata_i[27]));
          check_field("last", 8'(want.last), 8'(m_tlast_i));
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Top of the I2C register access sequencer testbench: clock, reset, request and done-report
// stimulus, receiver backpressure and the verdict. Depends on i2cras_pkg, the block and
// i2cras_result_checker, which does all prediction and comparison.
module tb_top;

  localparam int CycleLimit = 400000;
  localparam int TotalItems = 500;
  localparam int DrainCycles = 20;

  logic        clk_i;
  logic        rst_ni   = 1'b0;
  logic        s_valid  = 1'b0;
  logic [39:0] s_data   = '0;
  logic [1:0]  s_user   = i2cras_pkg::FUNC_DONE;
  logic        m_ready  = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [31:0] m_data;
  logic [1:0]  m_user;
  logic        m_last;
  int          fail_count;
  int          pending;

  // Idle rates in percent of cycles, changed per phase of the run
  int send_idle_pct = 36;
  int recv_idle_pct = 54;

  // Result counts seen on the output, used to pace the done reports
  int n_cmd_seen  = 0;
  int n_fin_seen  = 0;
  int n_fin_fail  = 0;
  int n_byte_seen = 0;
  int n_requests  = 0;
  int stim_items  = 0;
  int cycles      = 0;

  i2c_register_access_sequencer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  i2cras_result_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .s_tuser_i    (s_user),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .m_tuser_i    (m_user),
    .m_tlast_i    (m_last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: drop tready at the current idle rate
  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Count output transfers by kind; the stimulus waits on these counts
  always @(posedge clk_i) begin
    if (m_valid && m_ready) begin
      case (m_user)
        i2cras_pkg::KIND_CMD:    n_cmd_seen  <= n_cmd_seen + 1;
        i2cras_pkg::KIND_BYTE:   n_byte_seen <= n_byte_seen + 1;
        i2cras_pkg::KIND_FINISH: begin
          n_fin_seen <= n_fin_seen + 1;
          if (!m_data[27]) n_fin_fail <= n_fin_fail + 1;
        end
        default: ;
      endcase
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles, pending);
      $display("** i2c_register_access_sequencer: FAILED **");
      $finish;
    end
  end

  function automatic logic [39:0] pack_item(input logic [3:0] dev, input logic [7:0] reg_num,
                                            input logic [7:0] value, input logic [8:0] cnt,
                                            input logic ack, input logic [7:0] rx);
    return {2'b00, rx, ack, cnt, value, reg_num, dev};
  endfunction

  // Pick the idle rates from how far the run has come: first sender 36 and receiver 54,
  // then the other way round, then no idling at all
  task automatic pick_idle_rates();
    if (stim_items < TotalItems / 3) begin
      send_idle_pct = 36;
      recv_idle_pct = 54;
    end else if (stim_items < 2 * TotalItems / 3) begin
      send_idle_pct = 54;
      recv_idle_pct = 36;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Offer one item and hold it until the transfer; idle before it at the sender rate.
  // tvalid stays high after the transfer so that back-to-back items need no second
  // assignment in one step; whoever waits next drops it.
  task automatic push_item(input logic [1:0] func, input logic [39:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= func;
    s_data  <= data;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  // Done report with random don't-care fields
  task automatic push_report(input logic ack);
    push_item(i2cras_pkg::FUNC_DONE,
              pack_item(4'($urandom_range(15)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 9'($urandom_range(511)),
                        ack, 8'($urandom_range(255))));
  endtask

  // Request that the block should ignore because a request is in progress
  task automatic push_busy_request();
    push_item(2'($urandom_range(2)), pack_item(4'($urandom_range(15)), 8'($urandom_range(255)),
                                               8'($urandom_range(255)), 9'($urandom_range(511)),
                                               1'($urandom_range(1)), 8'($urandom_range(255))));
  endtask

  // Issue one request and answer each controller command with a done report until the
  // request finishes. Every report taken while busy yields exactly one command or the
  // finish, so commands seen beyond the reports sent mean the block waits on a report.
  // nak_at forces a missing ack on that report; noise_pct mixes in ignored requests
  // and doubled reports.
  task automatic run_access(input logic [1:0] func, input logic [3:0] dev,
                            input logic [7:0] reg_num, input logic [7:0] value,
                            input logic [8:0] cnt, input int ack_pct, input int nak_at,
                            input int noise_pct);
    int cmd0;
    int fin0;
    int sent;
    logic ack;
    logic finished;
    cmd0 = n_cmd_seen;
    fin0 = n_fin_seen;
    sent = 0;
    finished = 1'b0;
    pick_idle_rates();
    n_requests++;
    stim_items++;
    push_item(func, pack_item(dev, reg_num, value, cnt, 1'($urandom_range(1)),
                              8'($urandom_range(255))));
    while (!finished) begin
      pick_idle_rates();
      while (n_fin_seen == fin0 && n_cmd_seen - cmd0 <= sent) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
      if (n_fin_seen != fin0) begin
        finished = 1'b1;
      end else begin
        if ($urandom_range(99) < noise_pct) push_busy_request();
        ack = (sent == nak_at) ? 1'b0 : ($urandom_range(99) < ack_pct);
        push_report(ack);
        sent++;
        stim_items++;
        // Broken sequence: a second report before the block has answered the first
        if ($urandom_range(99) < noise_pct) begin
          push_report(($urandom_range(99) < ack_pct));
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int       pick;
    int       ack_pct;
    logic [1:0] func;
    logic [3:0] dev;
    logic [8:0] cnt;

    // Hold reset, then release it ahead of the first request
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes, every request, unknown device, retries, give-ups
    run_access(i2cras_pkg::FUNC_READ,  4'd0,  8'h00, 8'h00, 9'd0,   100, -1, 0);
    run_access(i2cras_pkg::FUNC_READ,  4'd14, 8'hFF, 8'hFF, 9'd511, 100, -1, 0);
    run_access(i2cras_pkg::FUNC_WRITE, 4'd3,  8'h80, 8'hFF, 9'd0,   100, -1, 0);
    run_access(i2cras_pkg::FUNC_WRITE, 4'd8,  8'h7F, 8'h00, 9'd0,   100, -1, 0);
    run_access(i2cras_pkg::FUNC_BURST, 4'd9,  8'h12, 8'h00, 9'd1,   100, -1, 0);
    run_access(i2cras_pkg::FUNC_BURST, 4'd5,  8'h34, 8'h00, 9'd0,   100, -1, 0);
    run_access(i2cras_pkg::FUNC_BURST, 4'd12, 8'h56, 8'h00, 9'd2,   100, -1, 0);
    run_access(i2cras_pkg::FUNC_BURST, 4'd2,  8'h78, 8'h00, 9'd511, 100, -1, 0);
    run_access(i2cras_pkg::FUNC_READ,  4'd15, 8'h01, 8'h00, 9'd0,   100, -1, 0);
    run_access(i2cras_pkg::FUNC_BURST, 4'd15, 8'h02, 8'h00, 9'd4,   100, -1, 0);
    run_access(i2cras_pkg::FUNC_WRITE, 4'd15, 8'h03, 8'hA5, 9'd0,   100, -1, 0);
    // Missing ack on addressing, on the register byte and on the final write check: abort and retry
    run_access(i2cras_pkg::FUNC_READ,  4'd1,  8'h10, 8'h00, 9'd0,   100, 0, 0);
    run_access(i2cras_pkg::FUNC_READ,  4'd4,  8'h11, 8'h00, 9'd0,   100, 2, 0);
    run_access(i2cras_pkg::FUNC_WRITE, 4'd6,  8'h20, 8'h5A, 9'd0,   100, 4, 0);
    run_access(i2cras_pkg::FUNC_WRITE, 4'd7,  8'h21, 8'hC3, 9'd0,   100, 1, 0);
    run_access(i2cras_pkg::FUNC_BURST, 4'd10, 8'h30, 8'h00, 9'd3,   100, 1, 0);
    // Never acknowledged: give up after all attempts
    run_access(i2cras_pkg::FUNC_READ,  4'd11, 8'h40, 8'h00, 9'd0,   0, -1, 0);
    run_access(i2cras_pkg::FUNC_WRITE, 4'd13, 8'h41, 8'h99, 9'd0,   0, -1, 0);
    run_access(i2cras_pkg::FUNC_BURST, 4'd0,  8'h42, 8'h00, 9'd4,   0, -1, 0);
    // Requests while busy and doubled reports throughout one burst
    run_access(i2cras_pkg::FUNC_BURST, 4'd3,  8'h50, 8'h00, 9'd5,   80, -1, 100);
    // Done reports while idle
    push_report(1'b1);
    push_report(1'b0);

    // Random part, up to the item budget of the whole run
    while (stim_items < TotalItems) begin
      // Stray reports while idle
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(3, 1)) push_report(1'($urandom_range(1)));
      end
      func = 2'($urandom_range(2));
      dev  = ($urandom_range(99) < 90) ? 4'($urandom_range(14)) : 4'd15;
      pick = $urandom_range(99);
      if (pick < 85) cnt = 9'($urandom_range(6));
      else if (pick < 98) cnt = 9'($urandom_range(40, 7));
      else cnt = 9'($urandom_range(511));
      if (func != i2cras_pkg::FUNC_BURST) cnt = 9'($urandom_range(511));
      pick = $urandom_range(99);
      if (pick < 70) ack_pct = 97;
      else if (pick < 90) ack_pct = 60;
      else ack_pct = 0;
      run_access(func, dev, 8'($urandom_range(255)), 8'($urandom_range(255)), cnt,
                 ack_pct, -1, 5);
    end

    // Drain: wait for every predicted result, then wait out DrainCycles for strays
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("ran %0d requests: %0d controller commands, %0d burst bytes delivered,",
             n_requests, n_cmd_seen, n_byte_seen);
    $display("%0d requests finished, %0d of them failed, in %0d cycles",
             n_fin_seen, n_fin_fail, cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("** i2c_register_access_sequencer: PASSED **");
    end else begin
      $display("** i2c_register_access_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
src/i2cras_pkg.sv
src/i2cras_step.sv
src/i2cras_outbuf.sv
src/i2c_register_access_sequencer.sv
tb/sv/i2cras_result_checker.sv
tb/sv/tb_top.sv
